// ===== design/rcuc_pkg.sv =====
// ----------------------------------------------------------------------------
// rcuc_pkg
// shared constants and types for the range cover / uncovered count block
// ----------------------------------------------------------------------------
package rcuc_pkg;

  // number of positions the mark store can hold
  localparam int unsigned POSITIONS = 65536;

  // width of the position fields, the length register and the count
  localparam int unsigned FIELD_W = 17;

  // bits per mark word and the offset width inside one word
  localparam int unsigned WORD_W = 64;
  localparam int unsigned BIT_W  = 6;

  // longest line the length register can express within the store
  localparam int unsigned FIELD_MAX = (1 << FIELD_W) - 1;
  localparam int unsigned LEN_MAX_I = (POSITIONS < FIELD_MAX) ? POSITIONS : FIELD_MAX;
  localparam logic [FIELD_W-1:0] LEN_MAX = FIELD_W'(LEN_MAX_I);

  // mark words that can ever be reached and their address width
  localparam int unsigned MEM_WORDS = (LEN_MAX_I + WORD_W - 1) / WORD_W;
  localparam int unsigned ADDR_W    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  // width of the count of ones in one word
  localparam int unsigned PC_W = BIT_W + 1;

  // length register after reset
  localparam logic [FIELD_W-1:0] LINE_LENGTH_RST = FIELD_W'(65536);

  typedef logic [ADDR_W-1:0] waddr_t;
  typedef logic [WORD_W-1:0] word_t;

  // range and line bounds of the range in flight, held for one sweep
  typedef struct packed {
    logic               rng_vld;  // range covers at least one position
    waddr_t             wa;       // first word touched by the range
    waddr_t             wb;       // last word touched by the range
    logic [BIT_W-1:0]   lo_bit;   // first bit inside the first word
    logic [BIT_W-1:0]   hi_bit;   // last bit inside the last word
    waddr_t             lw;       // last word of the line
    logic [BIT_W-1:0]   rem;      // used bits of the last line word, zero when full
  } sweep_ctl_t;

  // word read back from the store, in the cycle after its address
  typedef struct packed {
    logic   vld;
    waddr_t addr;
  } rd_stage_t;

endpackage

// ===== design/range_cover_uncovered_count.sv =====
// ----------------------------------------------------------------------------
// range_cover_uncovered_count
// covers inclusive position ranges on a line held as a mark bitmap and
// reports the number of positions still uncovered after each range
// ----------------------------------------------------------------------------
//
//  channel   | ports                           | handshake
//  ----------+---------------------------------+-----------------------------
//  range in  | first_i, last_i                 | start_i high, busy_o low
//  count out | uncovered_o                     | done_o, one cycle, no stall
//  config    | cfg_wdata_i (line length)       | cfg_we_i, no wait
//
//  after reset the mark store is cleared one word a cycle, all MEM_WORDS
//  words (1024 at 65536 positions), with busy_o high; config writes still land.
//  each range walks every word of the line through the single read port,
//  read-modify-write one word a cycle, then drains the pipeline; an empty line
//  skips the walk. busy_o drops with done_o.
//  done_o cannot be held off; uncovered_o holds the count until the next done_o.
//
module range_cover_uncovered_count (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rcuc_pkg::FIELD_W-1:0] cfg_wdata_i,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [rcuc_pkg::FIELD_W-1:0] first_i,
  input  logic [rcuc_pkg::FIELD_W-1:0] last_i,
  output logic                        done_o,
  output logic [rcuc_pkg::FIELD_W-1:0] uncovered_o
);
  import rcuc_pkg::*;

  // sequencer states
  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [FIELD_W-1:0] line_length_q;
  logic [FIELD_W-1:0] len_q;
  logic [FIELD_W-1:0] acc_q, acc_d;
  sweep_ctl_t         ctl_q;
  waddr_t             clr_q, clr_d;
  waddr_t             w_q, w_d;
  rd_stage_t          rd_q;
  logic               done_q, done_d;
  logic [FIELD_W-1:0] uncovered_q;

  // range preparation at accept
  logic [FIELD_W-1:0] len_eff;
  logic [FIELD_W-1:0] first_c;
  logic [FIELD_W-1:0] last_c;
  logic [FIELD_W-1:0] pos_a;
  logic [FIELD_W-1:0] pos_b;
  logic [FIELD_W-1:0] len_m1;
  sweep_ctl_t         ctl_d;
  logic               accept;

  // store ports
  logic   rd_en;
  word_t  rd_data;
  logic   wu_we;
  waddr_t wu_addr;
  word_t  wu_data;
  logic   ram_we;
  waddr_t ram_waddr;
  word_t  ram_wdata;
  logic   pc_vld;
  logic [PC_W-1:0] pc;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;

  // line length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q <= LINE_LENGTH_RST;
    end else if (cfg_we_i) begin
      line_length_q <= cfg_wdata_i;
    end
  end

  // clamp the range to the line and split it into words and bit offsets
  always_comb begin
    len_eff = (line_length_q > LEN_MAX) ? LEN_MAX : line_length_q;
    first_c = (first_i == '0) ? FIELD_W'(1) : first_i;
    last_c  = (last_i > len_eff) ? len_eff : last_i;
    pos_a   = first_c - FIELD_W'(1);
    pos_b   = last_c - FIELD_W'(1);
    len_m1  = len_eff - FIELD_W'(1);
    ctl_d.rng_vld = (first_c <= last_c);
    ctl_d.wa      = pos_a[BIT_W +: ADDR_W];
    ctl_d.wb      = pos_b[BIT_W +: ADDR_W];
    ctl_d.lo_bit  = pos_a[BIT_W-1:0];
    ctl_d.hi_bit  = pos_b[BIT_W-1:0];
    ctl_d.lw      = len_m1[BIT_W +: ADDR_W];
    ctl_d.rem     = len_eff[BIT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctl_q <= ctl_d;
      len_q <= len_eff;
    end
  end

  // sequencer: clearing pass, idle, word sweep, pipeline drain
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    w_d     = w_q;
    acc_d   = acc_q;
    done_d  = 1'b0;
    rd_en   = 1'b0;
    if (pc_vld) begin
      acc_d = acc_q + FIELD_W'(pc);
    end
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(MEM_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          w_d     = '0;
          acc_d   = '0;
          state_d = (len_eff == '0) ? S_DRAIN : S_SWEEP;
        end
      end
      S_SWEEP: begin
        rd_en = 1'b1;
        w_d   = w_q + ADDR_W'(1);
        if (w_q == ctl_q.lw) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_q.vld && !pc_vld) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      w_q     <= '0;
      acc_q   <= '0;
      done_q  <= 1'b0;
      rd_q    <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      w_q     <= w_d;
      acc_q   <= acc_d;
      done_q  <= done_d;
      rd_q.vld  <= rd_en;
      rd_q.addr <= w_q;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (done_d) begin
      uncovered_q <= len_q - acc_q;
    end
  end

  assign done_o      = done_q;
  assign uncovered_o = uncovered_q;

  // write port: clearing pass or write back from the word unit
  assign ram_we    = (state_q == S_CLEAR) || wu_we;
  assign ram_waddr = (state_q == S_CLEAR) ? clr_q : wu_addr;
  assign ram_wdata = (state_q == S_CLEAR) ? '0 : wu_data;

  rcuc_mark_ram u_mark_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (rd_en),
    .rd_addr_i (w_q),
    .rd_data_o (rd_data)
  );

  rcuc_word_unit u_word_unit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl_q),
    .rd_i      (rd_q),
    .rd_data_i (rd_data),
    .wr_en_o   (wu_we),
    .wr_addr_o (wu_addr),
    .wr_data_o (wu_data),
    .pc_vld_o  (pc_vld),
    .pc_o      (pc)
  );

  // a result only follows a range being worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("count word without a range in progress");

  // the covered count never exceeds the line it was taken over
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (acc_q <= len_q))
    else $error("covered count beyond line length");

  // the store is left alone while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !ram_we)
    else $error("mark store written while idle");

  // write back never goes past the last word of the line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wu_we |-> (wu_addr <= ctl_q.lw))
    else $error("write back beyond line end");

  // an accepted range makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("range accepted but block not busy");

endmodule

// ===== design/rcuc_mark_ram.sv =====
// ----------------------------------------------------------------------------
// rcuc_mark_ram
// one write port, one read port mark store with registered read data
// ----------------------------------------------------------------------------
module rcuc_mark_ram (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  rcuc_pkg::waddr_t     wr_addr_i,
  input  rcuc_pkg::word_t      wr_data_i,
  input  logic                 rd_en_i,
  input  rcuc_pkg::waddr_t     rd_addr_i,
  output rcuc_pkg::word_t      rd_data_o
);
  import rcuc_pkg::*;

  word_t mem_q [MEM_WORDS];
  word_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port with registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/rcuc_word_unit.sv =====
// ----------------------------------------------------------------------------
// rcuc_word_unit
// merges the range into one read-back mark word, writes it back and counts
// the covered bits that lie on the line
// ----------------------------------------------------------------------------
module rcuc_word_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rcuc_pkg::sweep_ctl_t      ctl_i,
  input  rcuc_pkg::rd_stage_t       rd_i,
  input  rcuc_pkg::word_t           rd_data_i,
  output logic                      wr_en_o,
  output rcuc_pkg::waddr_t          wr_addr_o,
  output rcuc_pkg::word_t           wr_data_o,
  output logic                      pc_vld_o,
  output logic [rcuc_pkg::PC_W-1:0] pc_o
);
  import rcuc_pkg::*;

  word_t            cover_mask;
  word_t            count_mask;
  word_t            new_word;
  logic             in_words;
  logic             at_wa;
  logic             at_wb;
  logic             at_lw;
  logic             pc_vld_q;
  logic [PC_W-1:0]  pc_q;

  // where this word sits against the range and the line end
  assign at_wa    = (rd_i.addr == ctl_i.wa);
  assign at_wb    = (rd_i.addr == ctl_i.wb);
  assign at_lw    = (rd_i.addr == ctl_i.lw);
  assign in_words = ctl_i.rng_vld && (rd_i.addr >= ctl_i.wa) && (rd_i.addr <= ctl_i.wb);

  // per bit masks for covering and for counting
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      cover_mask[i] = in_words
                      && (!at_wa || (BIT_W'(i) >= ctl_i.lo_bit))
                      && (!at_wb || (BIT_W'(i) <= ctl_i.hi_bit));
      count_mask[i] = !at_lw || (ctl_i.rem == '0) || (BIT_W'(i) < ctl_i.rem);
    end
  end

  assign new_word = rd_data_i | cover_mask;

  // write back in the cycle the word arrives
  assign wr_en_o   = rd_i.vld;
  assign wr_addr_o = rd_i.addr;
  assign wr_data_o = new_word;

  // registered count of covered bits on the line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_vld_q <= 1'b0;
    end else begin
      pc_vld_q <= rd_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    pc_q <= PC_W'($countones(new_word & count_mask));
  end

  assign pc_vld_o = pc_vld_q;
  assign pc_o     = pc_q;

endmodule

// ===== tb/range_count_checker.sv =====
// ----------------------------------------------------------------------------
// range_count_checker
// watches the range, count and config channels of the range cover block,
// keeps its own mark bitmap and line length, predicts the uncovered count
// of every accepted range word and compares it with each count word
// ----------------------------------------------------------------------------
module range_count_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rcuc_pkg::FIELD_W-1:0] cfg_wdata_i,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic [rcuc_pkg::FIELD_W-1:0] first_i,
  input  logic [rcuc_pkg::FIELD_W-1:0] last_i,
  input  logic                         done_i,
  input  logic [rcuc_pkg::FIELD_W-1:0] uncovered_i,
  output int                           errors_o,
  output int                           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import rcuc_pkg::*;

  // shadow of the mark store and of the length register
  logic [WORD_W-1:0]  mark_words [MEM_WORDS];
  logic [FIELD_W-1:0] line_len;

  // counts still to come from the block, oldest first
  logic [FIELD_W-1:0] expected_counts [$];
  int                 errors;

  // mark [first,last] clipped to the line, then count the gaps left on it
  function automatic logic [FIELD_W-1:0] cover_and_count(input logic [FIELD_W-1:0] first,
                                                          input logic [FIELD_W-1:0] last);
    int unsigned len, lo_pos, hi_pos, wa, wb, lo, hi, full, rem, hits;
    logic [WORD_W-1:0] mask;
    len    = (line_len > POSITIONS) ? POSITIONS : line_len;
    lo_pos = (first == '0) ? 1 : first;
    hi_pos = (last > len) ? len : last;
    if (lo_pos <= hi_pos) begin
      wa = (lo_pos - 1) >> BIT_W;
      wb = (hi_pos - 1) >> BIT_W;
      for (int unsigned w = wa; w <= wb; w++) begin
        lo   = (w == wa) ? ((lo_pos - 1) & (WORD_W - 1)) : 0;
        hi   = (w == wb) ? ((hi_pos - 1) & (WORD_W - 1)) : WORD_W - 1;
        mask = ({WORD_W{1'b1}} >> (WORD_W - 1 - (hi - lo))) << lo;
        mark_words[w] |= mask;
      end
    end
    // recount the covered positions over the whole line
    full = len >> BIT_W;
    rem  = len & (WORD_W - 1);
    hits = 0;
    for (int unsigned w = 0; w < full; w++)
      hits += $countones(mark_words[w]);
    if (rem != 0)
      hits += $countones(mark_words[full] & ((64'd1 << rem) - 64'd1));
    return FIELD_W'(len - hits);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [FIELD_W-1:0] want;
    if (!rst_ni) begin
      for (int w = 0; w < MEM_WORDS; w++)
        mark_words[w] = '0;
      line_len = LINE_LENGTH_RST;
      expected_counts.delete();
      errors    = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      // count word out: compare with the oldest prediction
      if (done_i) begin
        if (expected_counts.size() == 0) begin
          errors++;
          $display("%0t: count word with nothing expected, expected none, got %0d",
                   $time, uncovered_i);
        end else begin
          want = expected_counts.pop_front();
          if (uncovered_i !== want) begin
            errors++;
            $display("%0t: uncovered count mismatch, expected %0d, got %0d",
                     $time, want, uncovered_i);
          end
        end
      end
      // range word accepted: predict its count
      if (start_i && !busy_i)
        expected_counts.push_back(cover_and_count(first_i, last_i));
      // a length written at this edge applies from the next word on
      if (cfg_we_i)
        line_len = cfg_wdata_i;
      errors_o  <= errors;
      pending_o <= expected_counts.size();
    end
  end

endmodule

// ===== tb/tb_range_cover_uncovered_count.sv =====
// ----------------------------------------------------------------------------
// tb_range_cover_uncovered_count
// drives directed and random range words into the range cover block in
// random bursts over a series of line lengths, from empty and single-position
// lines up to the saturating length, and lets the checker compare every
// uncovered count
module tb_range_cover_uncovered_count;
  timeunit 1ns;
  timeprecision 1ps;

  import rcuc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int          DIRECTED_N  = 20;
  localparam int          PHASE_N     = 14;

  typedef enum int {
    RANGE_FIRST_ZERO,
    RANGE_EMPTY,
    RANGE_ANY,
    RANGE_PAST_END,
    RANGE_INSIDE
  } range_kind_e;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [FIELD_W-1:0] cfg_wdata_i;
  logic               start_i;
  logic               busy_o;
  logic [FIELD_W-1:0] first_i;
  logic [FIELD_W-1:0] last_i;
  logic               done_o;
  logic [FIELD_W-1:0] uncovered_o;

  int          errors;
  int          pending;
  int unsigned cycle_count = 0;
  int          burst_left;

  // line edges, word boundaries, repeats and overlaps at the reset length
  int unsigned dir_first [DIRECTED_N] = '{1, 65536, 0, 10, 0, 2, 64, 63, 128, 1000,
                                           1000, 4999, 65000, 131071, 65536, 70000,
                                           32768, 65535, 43690, 21845};
  int unsigned dir_last  [DIRECTED_N] = '{1, 65536, 5, 5, 0, 7, 65, 64, 128, 5000,
                                           5000, 5100, 131071, 131071, 1, 80000,
                                           32768, 65535, 43690, 21847};

  // line length and number of random words for each phase
  int unsigned phase_len   [PHASE_N] = '{0, 1, 63, 64, 65, 200, 500, 2000, 9000,
                                          40000, 65536, 131071, 100, 131071};
  int          phase_items [PHASE_N] = '{10, 15, 40, 40, 40, 100, 80, 80, 60,
                                          30, 15, 3, 40, 3};

  range_cover_uncovered_count DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .first_i     (first_i),
    .last_i      (last_i),
    .done_o      (done_o),
    .uncovered_o (uncovered_o)
  );

  range_count_checker u_count_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .first_i     (first_i),
    .last_i      (last_i),
    .done_i      (done_o),
    .uncovered_i (uncovered_o),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // run guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // hold a range word until the block takes it; start stays high afterwards
  task automatic put_range(input int unsigned f, input int unsigned l);
    start_i <= 1'b1;
    first_i <= FIELD_W'(f);
    last_i  <= FIELD_W'(l);
    do @(posedge clk_i); while (busy_o);
  endtask

  // bursts of back-to-back words with random gaps between them
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 6);
      start_i <= 1'b0;
      first_i <= FIELD_W'($urandom);
      last_i  <= FIELD_W'($urandom);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
                                               : $urandom_range(0, 4);
    end
  endtask

  // stop sending and wait for every count still due
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy_o) @(posedge clk_i);
  endtask

  initial begin
    int unsigned f, l, le, span, r;
    range_kind_e kind;
    burst_left  = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    start_i     = 1'b0;
    first_i     = '0;
    last_i      = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words at the reset length
    for (int i = 0; i < DIRECTED_N; i++) begin
      put_range(dir_first[i], dir_last[i]);
      pace();
    end

    // random words over a series of line lengths
    for (int p = 0; p < PHASE_N; p++) begin
      drain();
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= FIELD_W'(phase_len[p]);
      @(posedge clk_i);
      cfg_we_i    <= 1'b0;
      le = (phase_len[p] > POSITIONS) ? POSITIONS : phase_len[p];
      for (int n = 0; n < phase_items[p]; n++) begin
        r    = $urandom_range(0, 31);
        kind = (r < 4) ? range_kind_e'(r) : RANGE_INSIDE;
        case (kind)
          RANGE_FIRST_ZERO: begin
            f = 0;
            l = $urandom_range(0, 40);
          end
          RANGE_EMPTY: begin
            f = $urandom_range(2, FIELD_MAX);
            l = $urandom_range(0, f - 1);
          end
          RANGE_ANY: begin
            f = $urandom & FIELD_MAX;
            l = $urandom & FIELD_MAX;
          end
          RANGE_PAST_END: begin
            f = le + 1 - $urandom_range(0, (le < 40) ? le : 40);
            l = $urandom_range(le, FIELD_MAX);
          end
          default: begin
            // short range starting inside the line, mostly narrow
            r    = $urandom_range(0, 2);
            span = (r == 0) ? 3 : (r == 1) ? 70 : le / 8;
            f    = $urandom_range(1, (le == 0) ? 1 : le);
            l    = f + $urandom_range(0, span);
          end
        endcase
        put_range(f, l);
        pace();
      end
    end

    // let any stray count word show up before the verdict
    drain();
    repeat (1100) @(posedge clk_i);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
